[design/dis_pkg.sv]
// Package for the dexel interval subtract unit: sizes, request codes and the
// front-to-back queue entry type. No dependencies.
`default_nettype none
package dis_pkg;
	localparam int CELLS = 4096;
	localparam int SEGS = 8;
	localparam int CELL_W = 12;
	localparam int SLOT_W = $clog2(SEGS);
	localparam int ADDR_W = $clog2(CELLS * SEGS);
	localparam int ENTRY_W = 32 + 32 + 16;
	localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_CUT  = 2'd1,
		REQ_READ = 2'd2,
		REQ_NOP  = 2'd3
	} req_t;

	// Request as classified by the front end.
	typedef struct packed {
		req_t              kind;      // REQ_NOP for out-of-range cells too
		logic [CELL_W-1:0] cell_idx;
		logic [2:0]        slot;
		logic              slot_ok;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic [15:0]       attr;
		logic              new_pass;
		logic              tool_empty;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_EVAL, ST_SPLIT_ADD, ST_SUM, ST_LOAD, ST_READ_WAIT,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

[design/dis_ram.sv]
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`default_nettype none
module dis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[design/dis_front.sv]
// Front end: accepts requests, classifies them and queues them for the back
// end in a two-entry FIFO. Depends on dis_pkg.
`default_nettype none
module dis_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          req_type,
	input  wire logic [11:0]         cell_index,
	input  wire logic [2:0]          slot_index,
	input  wire logic signed [31:0]  span_lo,
	input  wire logic signed [31:0]  span_hi,
	input  wire logic [15:0]         span_attr,
	input  wire logic                new_pass,
	output logic                     cmd_valid,
	input  wire logic                cmd_ready,
	output dis_pkg::cmd_t            cmd
);
	import dis_pkg::*;

	cmd_t  fifo_q [2];
	logic  wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t  cls;
	logic  push, pop;

	always_comb begin
		cls.kind = req_t'(req_type);
		if ({20'd0, cell_index} >= 32'(CELLS)) begin
			cls.kind = REQ_NOP;
		end
		cls.cell_idx = cell_index;
		cls.slot = slot_index;
		cls.slot_ok = ({29'd0, slot_index} < 32'(SEGS));
		cls.lo = span_lo;
		cls.hi = span_hi;
		cls.attr = span_attr;
		cls.new_pass = new_pass;
		cls.tool_empty = (span_lo >= span_hi);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop = cmd_valid && cmd_ready;
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

[design/dis_back.sv]
// Back end: loads and reads slots of one cell, and for a cut walks its slots
// through the slot RAM, trims, erases and splits intervals, and keeps the cut total and interval count.
// Depends on dis_pkg and dis_ram.
`default_nettype none
module dis_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_ready,
	input  wire dis_pkg::cmd_t      cmd,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [47:0]             cut_total,
	output logic                    overflow,
	output logic                    read_present,
	output logic signed [31:0]      read_lo,
	output logic signed [31:0]      read_hi,
	output logic [15:0]             read_attr,
	output logic [15:0]             segment_count
);
	import dis_pkg::*;

	localparam int NCELL_ENT = CELLS * SEGS;

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [SEGS-1:0] used_row, todo_q, used_new_q;
	logic [SLOT_W:0] idx_q;
	logic [SLOT_W-1:0] slot_cur;
	logic [47:0] sum_q;
	logic [16:0] count_q;
	logic ovf_q;
	logic signed [32:0] add_len_q;

	// Used bits: a memory of SEGS-wide rows, cleared by a pass after reset.
	logic [CELL_W:0] clr_q;
	logic clearing;
	logic used_we;
	logic [CELL_W-1:0] used_waddr;
	logic [SEGS-1:0] used_wdata;

	// Slot data RAM.
	logic ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic signed [31:0] bs, be;
	logic [15:0] btag;

	logic [SLOT_W-1:0] free_idx;
	logic free_ok;

	logic in_cut, hit, covered, trim_lo, trim_hi, split;

	assign clearing = !clr_q[CELL_W];
	assign slot_cur = idx_q[SLOT_W-1:0];

	dis_ram #(.WIDTH(SEGS), .DEPTH(CELLS)) u_used (
		.clk(clk), .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
		.raddr(cmd.cell_idx), .rdata(used_row)
	);

	dis_ram #(.WIDTH(ENTRY_W), .DEPTH(NCELL_ENT)) u_slots (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign bs = ram_rdata[ENTRY_W-1 -: 32];
	assign be = ram_rdata[47:16];
	assign btag = ram_rdata[15:0];

	// First free slot in the live used vector.
	always_comb begin
		free_idx = '0;
		free_ok = 1'b0;
		for (int i = SEGS - 1; i >= 0; i--) begin
			if (!used_new_q[i]) begin
				free_idx = SLOT_W'(i);
				free_ok = 1'b1;
			end
		end
	end

	assign cmd_ready = (state_q == ST_IDLE) && !clearing;

	// Slot walk: in ST_EVAL the read data of slot idx_q is present.
	always_comb begin
		in_cut = todo_q[slot_cur] && !cmd_q.tool_empty && (idx_q < (SLOT_W+1)'(SEGS));
		hit = in_cut && !(bs > be) && !(cmd_q.hi <= bs) && !(cmd_q.lo >= be);
		covered = hit && cmd_q.lo <= bs && cmd_q.hi >= be;
		trim_lo = hit && !covered && cmd_q.lo <= bs;
		trim_hi = hit && !covered && !trim_lo && cmd_q.hi >= be;
		split = hit && !covered && !trim_lo && !trim_hi;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (cmd_valid && !clearing) state_d = ST_RD;
			ST_RD: begin
				case (cmd_q.kind)
					REQ_LOAD: state_d = ST_LOAD;
					REQ_CUT:  state_d = ST_EVAL;
					REQ_READ: state_d = ST_READ_WAIT;
					default:  state_d = ST_OUT;
				endcase
			end
			// A split goes through ST_SPLIT_ADD for its second write.
			ST_EVAL: state_d = (split && free_ok) ? ST_SPLIT_ADD : ST_SUM;
			ST_SPLIT_ADD: state_d = ST_SUM;
			ST_SUM: state_d = (idx_q == (SLOT_W+1)'(SEGS)) ? ST_OUT : ST_EVAL;
			ST_LOAD: state_d = ST_OUT;
			ST_READ_WAIT: state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = {cmd_q.cell_idx, slot_cur};
		ram_wdata = ram_rdata;
		ram_raddr = {cmd_q.cell_idx, slot_cur};
		used_we = 1'b0;
		used_waddr = cmd_q.cell_idx;
		used_wdata = used_new_q;
		if (clearing) begin
			used_we = 1'b1;
			used_waddr = clr_q[CELL_W-1:0];
			used_wdata = '0;
		end else begin
			case (state_q)
				ST_IDLE: ram_raddr = {cmd.cell_idx, SLOT_W'(0)};
				ST_RD: begin
					if (cmd_q.kind == REQ_READ) begin
						ram_raddr = {cmd_q.cell_idx, cmd_q.slot[SLOT_W-1:0]};
					end
				end
				ST_EVAL: begin
					if (trim_lo) begin
						ram_we = 1'b1;
						ram_wdata = {cmd_q.hi, be, btag};
					end else if (trim_hi) begin
						ram_we = 1'b1;
						ram_wdata = {bs, cmd_q.lo, btag};
					end else if (split && free_ok) begin
						ram_we = 1'b1;
						ram_wdata = {bs, cmd_q.lo, btag};
					end
				end
				ST_SPLIT_ADD: begin
					// The new piece; the original row's data is still latched.
					ram_we = 1'b1;
					ram_waddr = {cmd_q.cell_idx, free_idx};
					ram_wdata = {cmd_q.hi, be, btag};
					ram_raddr = {cmd_q.cell_idx, slot_cur};
				end
				ST_SUM: begin
					ram_raddr = {cmd_q.cell_idx, slot_cur};
					if (idx_q == (SLOT_W+1)'(SEGS) && cmd_q.kind == REQ_CUT) begin
						used_we = 1'b1;
					end
				end
				ST_LOAD: begin
					if (free_ok) begin
						ram_we = 1'b1;
						ram_waddr = {cmd_q.cell_idx, free_idx};
						ram_wdata = {cmd_q.lo, cmd_q.hi, cmd_q.attr};
						used_we = 1'b1;
						used_wdata = used_new_q | (SEGS'(1) << free_idx);
					end
				end
				default: ;
			endcase
		end
	end

	logic [48:0] sum_add;
	assign sum_add = {1'b0, sum_q} + {{16{1'b0}}, add_len_q[32:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q <= '0;
			sum_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			todo_q <= '0;
			used_new_q <= '0;
			ovf_q <= 1'b0;
			add_len_q <= '0;
			read_present <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_q <= clr_q + 1'b1;
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					ovf_q <= 1'b0;
					add_len_q <= '0;
					read_present <= 1'b0;
				end
				ST_RD: begin
					todo_q <= used_row;
					used_new_q <= used_row;
					if (cmd_q.kind == REQ_CUT && cmd_q.new_pass) sum_q <= '0;
				end
				ST_EVAL: begin
					add_len_q <= '0;
					if (covered) begin
						used_new_q[slot_cur] <= 1'b0;
						count_q <= count_q - 17'd1;
						add_len_q <= 33'(be) - 33'(bs);
					end else if (trim_lo) begin
						add_len_q <= 33'(cmd_q.hi) - 33'(bs);
					end else if (trim_hi) begin
						add_len_q <= 33'(be) - 33'(cmd_q.lo);
					end else if (split) begin
						if (free_ok) begin
							add_len_q <= 33'(cmd_q.hi) - 33'(cmd_q.lo);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					if (!(split && free_ok)) idx_q <= idx_q + 1'b1;
				end
				ST_SPLIT_ADD: begin
					used_new_q[free_idx] <= 1'b1;
					count_q <= count_q + 17'd1;
					idx_q <= idx_q + 1'b1;
				end
				ST_SUM: begin
					sum_q <= sum_add[48] || sum_add[47:0] > SUM_MAX ? SUM_MAX
						: sum_add[47:0];
					add_len_q <= '0;
				end
				ST_LOAD: begin
					if (free_ok) count_q <= count_q + 17'd1;
					else ovf_q <= 1'b1;
				end
				ST_READ_WAIT: read_present <= cmd_q.slot_ok && used_new_q[cmd_q.slot[SLOT_W-1:0]];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid && !clearing) cmd_q <= cmd;
	end

	logic [ENTRY_W-1:0] rd_hold_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_READ_WAIT) rd_hold_q <= ram_rdata;
	end

	assign out_valid = (state_q == ST_OUT);
	assign cut_total = sum_q;
	assign overflow = ovf_q;
	assign read_lo = read_present ? rd_hold_q[ENTRY_W-1 -: 32] : '0;
	assign read_hi = read_present ? rd_hold_q[47:16] : '0;
	assign read_attr = read_present ? rd_hold_q[15:0] : '0;
	assign segment_count = count_q[16] ? 16'hFFFF : count_q[15:0];
endmodule
`default_nettype wire

[design/dexel_interval_subtract_unit.sv]
// Top level of the dexel interval subtract unit: front end, queue and back end.
// Depends on dis_pkg, dis_front, dis_back and dis_ram.
// Throughput: one request at a time in the back end, set by the single slot RAM
// port walking the cell's SEGS slots; the front queue holds two more requests.
// After reset a clearing pass zeroes the used-bit rows; no request is processed
// until it finishes.
`default_nettype none
module dexel_interval_subtract_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         req_type,
	input  wire logic [11:0]        cell_index,
	input  wire logic [2:0]         slot_index,
	input  wire logic signed [31:0] span_lo,
	input  wire logic signed [31:0] span_hi,
	input  wire logic [15:0]        span_attr,
	input  wire logic               new_pass,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [47:0]             cut_total,
	output logic                    overflow,
	output logic                    read_present,
	output logic signed [31:0]      read_lo,
	output logic signed [31:0]      read_hi,
	output logic [15:0]             read_attr,
	output logic [15:0]             segment_count
);
	import dis_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_ready;

	dis_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .req_type, .cell_index, .slot_index,
		.span_lo, .span_hi, .span_attr, .new_pass,
		.cmd_valid, .cmd_ready, .cmd
	);

	dis_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready,
		.cut_total, .overflow, .read_present, .read_lo, .read_hi, .read_attr,
		.segment_count
	);

	// A read result that reports no interval carries zero data.
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_present |-> read_lo == '0 && read_hi == '0)
		else $error("empty read with data");

	// The result holds while it is stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cut_total)
		&& $stable(segment_count))
		else $error("result changed under stall");
endmodule
`default_nettype wire
